@@ sv/sliding_frame_sync_xor_check_defines.svh @@
// ----------------------------------------------------------------------------
// sliding_frame_sync_xor_check_defines.svh
// Assertion macros used by the checker file of the frame sync block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_FRAME_SYNC_XOR_CHECK_DEFINES_SVH
`define SLIDING_FRAME_SYNC_XOR_CHECK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFSX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFSX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sfsx_pkg.sv @@
// ----------------------------------------------------------------------------
// sfsx_pkg
// Sizes, register codes and shared types of the frame sync block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsx_pkg;

	localparam int FRAME_BYTES = 103;
	localparam int WORD_COUNT  = 25;
	localparam int BYTE_W      = 8;
	localparam int WORD_W      = 32;
	localparam int WI_W        = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int Q_DEPTH     = 2;

	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
	localparam int PAY_BYTES      = WORD_COUNT * BYTES_PER_WORD;

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START_MARKER = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_END_MARKER   = cfg_idx_t'(1);

	localparam byte_t START_MARKER_RST = 8'h40;
	localparam byte_t END_MARKER_RST   = 8'h2B;

	// One matched frame: checksum verdict and its payload words.
	typedef struct packed {
		logic                             bad;
		logic [WORD_COUNT-1:0][WORD_W-1:0] words;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

@@ sv/sfsx_if.sv @@
// ----------------------------------------------------------------------------
// sfsx_if
// Valid/ready channels of the frame sync block: byte in, config, results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfsx_rx_if;
	import sfsx_pkg::*;
	logic  valid;
	logic  ready;
	byte_t rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsx_cfg_if;
	import sfsx_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	byte_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

interface sfsx_res_if;
	import sfsx_pkg::*;
	logic              valid;
	logic              ready;
	logic              status;
	logic [WI_W-1:0]   word_index;
	logic [WORD_W-1:0] word_value;
	logic              last_word;
	modport source (output valid, output status, output word_index, output word_value,
		output last_word, input ready);
	modport sink   (input valid, input status, input word_index, input word_value,
		input last_word, output ready);
endinterface

`default_nettype wire

@@ sv/sfsx_front.sv @@
// ----------------------------------------------------------------------------
// sfsx_front
// Byte window, running checksum, marker test and frame capture.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsx_front (
	input  logic             clk,
	input  logic             arst_n,
	sfsx_cfg_if.sink         cfg,
	sfsx_rx_if.sink          rx,
	input  sfsx_pkg::q_stat_t q_stat,
	output logic             push,
	output sfsx_pkg::frame_t push_frame
);
	import sfsx_pkg::*;

	byte_t             win_q [FRAME_BYTES];
	byte_t             win_d [FRAME_BYTES];
	logic [FILL_W-1:0] fill_q;
	byte_t             xor_q;
	byte_t             xor_d;
	byte_t             start_q;
	byte_t             end_q;
	logic              full;
	logic              take;
	logic              hit;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !q_stat.full;
	assign take      = rx.valid && rx.ready;
	assign full      = (fill_q == FILL_W'(FRAME_BYTES));

	// Next window: shift when full, else append at the fill position.
	always_comb begin
		for (int j = 0; j < FRAME_BYTES - 1; j++) begin
			if (full) begin
				win_d[j] = win_q[j+1];
			end else if (fill_q == FILL_W'(j)) begin
				win_d[j] = rx.rx_byte;
			end else begin
				win_d[j] = win_q[j];
			end
		end
		if (full || fill_q == FILL_W'(FRAME_BYTES - 1)) begin
			win_d[FRAME_BYTES-1] = rx.rx_byte;
		end else begin
			win_d[FRAME_BYTES-1] = win_q[FRAME_BYTES-1];
		end
	end

	// Running XOR over positions two through next-to-last.
	always_comb begin
		if (full) begin
			xor_d = xor_q ^ win_q[2] ^ win_q[FRAME_BYTES-1];
		end else if (fill_q >= FILL_W'(2) && fill_q <= FILL_W'(FRAME_BYTES - 2)) begin
			xor_d = xor_q ^ rx.rx_byte;
		end else begin
			xor_d = xor_q;
		end
	end

	assign hit  = (win_d[0] == start_q) && (win_d[FRAME_BYTES-1] == end_q);
	assign push = take && hit;

	always_comb begin
		push_frame.bad   = (xor_d != win_d[1]);
		push_frame.words = '0;
		for (int j = 0; j < PAY_BYTES; j++) begin
			if (j + 2 < FRAME_BYTES) begin
				push_frame.words[j/BYTES_PER_WORD][(j%BYTES_PER_WORD)*BYTE_W +: BYTE_W] =
					win_d[(j + 2 < FRAME_BYTES) ? j + 2 : 0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			xor_q  <= '0;
			for (int j = 0; j < FRAME_BYTES; j++) begin
				win_q[j] <= '0;
			end
		end else if (take) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
			xor_q <= xor_d;
			for (int j = 0; j < FRAME_BYTES; j++) begin
				win_q[j] <= win_d[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_MARKER_RST;
			end_q   <= END_MARKER_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_START_MARKER: start_q <= cfg.data;
				CFG_END_MARKER:   end_q   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/sfsx_queue.sv @@
// ----------------------------------------------------------------------------
// sfsx_queue
// Short frame queue between the window front and the word back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sfsx_pkg::frame_t  push_frame,
	input  logic              pop,
	output sfsx_pkg::frame_t  head,
	output sfsx_pkg::q_stat_t q_stat
);
	import sfsx_pkg::*;

	frame_t           mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (cnt_q == (PTR_W+1)'(Q_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
		end
	end

endmodule

`default_nettype wire

@@ sv/sfsx_back.sv @@
// ----------------------------------------------------------------------------
// sfsx_back
// Walks the queue head frame and drives one result per cycle while res is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sfsx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfsx_pkg::frame_t  head,
	input  sfsx_pkg::q_stat_t q_stat,
	output logic              pop,
	sfsx_res_if.source        res
);
	import sfsx_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              ovalid_q;
	logic              ostatus_q;
	logic [WI_W-1:0]   oindex_q;
	logic [WORD_W-1:0] ovalue_q;
	logic              olast_q;
	logic              can_load;
	logic              go;
	logic              last;

	assign can_load = !ovalid_q || res.ready;
	assign go       = can_load && !q_stat.empty;
	assign last     = head.bad || (idx_q == IDX_W'(WORD_COUNT - 1));
	assign pop      = go && last;

	assign res.valid      = ovalid_q;
	assign res.status     = ostatus_q;
	assign res.word_index = oindex_q;
	assign res.word_value = ovalue_q;
	assign res.last_word  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else if (can_load) begin
			ovalid_q <= go;
			if (go) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ostatus_q <= head.bad;
			olast_q   <= last;
			if (head.bad) begin
				oindex_q <= '0;
				ovalue_q <= '0;
			end else begin
				oindex_q <= WI_W'(idx_q);
				ovalue_q <= head.words[idx_q];
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/sliding_frame_sync_xor_check.sv @@
// ----------------------------------------------------------------------------
// sliding_frame_sync_xor_check
// Marker-framed packet receiver with an XOR checksum over a sliding window.
// ----------------------------------------------------------------------------
// Feed one link byte per request on rx; one byte is taken every clock while
// the frame queue has room. The last FRAME_BYTES bytes sit in a register
// window (cleared by reset, no clearing pass) next to a running XOR of bytes
// two through next-to-last, so the marker test and checksum verdict for each
// byte are combinational. Each byte that puts the start marker at window
// position zero and the end marker at the last position captures its payload
// into a two-entry frame queue. The back end drives one result per cycle on res
// while res is ready: WORD_COUNT little-endian payload words for a good frame,
// or a single error result with status set for a checksum mismatch. A good
// frame thus occupies the result port for WORD_COUNT results; rx stalls only
// when two captured frames are waiting. Write the markers on cfg only while
// idle; cfg is always ready, and an index past the register list is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_frame_sync_xor_check (
	input  logic       clk,
	input  logic       arst_n,
	sfsx_cfg_if.sink   cfg,
	sfsx_rx_if.sink    rx,
	sfsx_res_if.source res
);
	import sfsx_pkg::*;

	logic    push;
	frame_t  push_frame;
	logic    pop;
	frame_t  head;
	q_stat_t q_stat;

	// Front: take bytes, advance the window, classify each byte.
	sfsx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.rx         (rx),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	// Hold captured frames so front and back stall independently.
	sfsx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back: drain the head frame one result at a time.
	sfsx_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res    (res)
	);

endmodule

`default_nettype wire

@@ sv/sfsx_checker.sv @@
// ----------------------------------------------------------------------------
// sfsx_checker
// Port-level checks on the result stream of the frame sync block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_frame_sync_xor_check_defines.svh"

module sfsx_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_status,
	input logic [sfsx_pkg::WI_W-1:0] out_word_index,
	input logic [sfsx_pkg::WORD_W-1:0] out_word_value,
	input logic                      out_last_word
);
	import sfsx_pkg::*;

	`SFSX_ASSERT_NEXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result request dropped while stalled")
	`SFSX_ASSERT_IMPL(a_err_shape, clk, arst_n, out_valid && out_status, out_last_word && out_word_index == '0 && out_word_value == '0, "malformed checksum error result")
	`SFSX_ASSERT_NEXT(a_word_run, clk, arst_n, out_valid && out_ready && !out_last_word, out_valid && !out_status && out_word_index == WI_W'($past(out_word_index) + 1'b1), "payload words not contiguous")
	`SFSX_ASSERT_IMPL(a_last_idx, clk, arst_n, out_valid && !out_status && out_last_word, out_word_index == WI_W'(WORD_COUNT - 1), "frame closed at wrong word")

endmodule

bind sliding_frame_sync_xor_check sfsx_checker u_sfsx_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.out_status     (res.status),
	.out_word_index (res.word_index),
	.out_word_value (res.word_value),
	.out_last_word  (res.last_word)
);

`default_nettype wire
